// ===== rtl/meg_pkg.sv =====
`timescale 1ns / 1ps

package meg_pkg;

    localparam int IMAGE_HEIGHT_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;

    // left shifts that place the pixel offset in Q8.24 over a Q16.16 divisor
    localparam int IMAG_SHIFT = 40;
    localparam int REAL_SHIFT = 39;

    localparam logic [1:0] CFG_ZOOM_SCALE = 2'd0;
    localparam logic [1:0] CFG_Y_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_X_OFFSET   = 2'd2;
    localparam logic [1:0] CFG_MAX_ITER   = 2'd3;

    localparam logic [31:0] ZOOM_SCALE_RST = 32'h0010_0000;
    localparam logic [11:0] MAX_ITER_RST   = 12'd240;

    // |z|^2 bound, 32.0 in Q16.48
    localparam logic [63:0] ESCAPE_LIMIT = 64'd32 << 48;

    typedef struct packed {
        logic        [31:0] zoom_scale;
        logic signed [31:0] y_offset;
        logic signed [31:0] x_offset;
        logic        [11:0] max_iter;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } t_point;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_DIV_I,
        FR_FIN_I,
        FR_DIV_R,
        FR_FIN_R,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_UPD,
        BK_DONE
    } t_back_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] colour_of(input logic [3:0] val);
        logic [2:0] c;
        case (val)
            4'd0, 4'd6, 4'd12: c = 3'd0;
            4'd1, 4'd7, 4'd13: c = 3'd1;
            4'd2, 4'd8, 4'd14: c = 3'd2;
            4'd3, 4'd9, 4'd15: c = 3'd3;
            4'd4, 4'd10:       c = 3'd4;
            default:           c = 3'd5;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] glyph_of(input logic [3:0] val);
        logic [6:0] g;
        case (val)
            4'd0:    g = 7'd32;
            4'd1:    g = 7'd46;
            4'd2:    g = 7'd44;
            4'd3:    g = 7'd42;
            4'd4:    g = 7'd126;
            4'd5:    g = 7'd42;
            4'd6:    g = 7'd94;
            4'd7:    g = 7'd58;
            4'd8:    g = 7'd59;
            4'd9:    g = 7'd124;
            4'd10:   g = 7'd38;
            4'd11:   g = 7'd91;
            4'd12:   g = 7'd36;
            4'd13:   g = 7'd37;
            4'd14:   g = 7'd64;
            default: g = 7'd35;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/meg_front.sv =====
`timescale 1ns / 1ps

module meg_front #(
    parameter int IMAGE_HEIGHT = meg_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [5:0]      i_row,
    input  logic [6:0]      i_col,
    input  meg_pkg::t_cfg   i_cfg,
    output logic            o_push,
    input  logic            i_full,
    output meg_pkg::t_point o_point
);

    // signed width of row - H/2 and column - H
    localparam int SW = $clog2(IMAGE_HEIGHT + 128) + 1;
    localparam int NW = SW + meg_pkg::IMAG_SHIFT;
    localparam int BW = $clog2(NW);

    meg_pkg::t_front_state r_state, n_state;

    logic [6:0]         r_col;
    logic [NW-1:0]      r_num;
    logic [31:0]        r_rem;
    logic [31:0]        r_q;
    logic               r_big;
    logic               r_neg;
    logic [BW-1:0]      r_bit;
    logic signed [31:0] r_ci, r_cr;

    logic signed [SW-1:0] d_i, d_r;
    logic [SW-1:0]        mag_i, mag_r;
    logic [31:0]          divisor;
    logic [32:0]          rem_sh;
    logic                 ge;
    logic [31:0]          rem_nx;
    logic signed [32:0]   q_sat;
    logic signed [31:0]   offset;
    logic signed [32:0]   diff;
    logic signed [31:0]   coord;

    assign d_i   = $signed(SW'(i_row)) - $signed(SW'(IMAGE_HEIGHT / 2));
    assign d_r   = $signed(SW'(r_col)) - $signed(SW'(IMAGE_HEIGHT));
    assign mag_i = d_i[SW-1] ? SW'(-d_i) : SW'(d_i);
    assign mag_r = d_r[SW-1] ? SW'(-d_r) : SW'(d_r);

    // a zero zoom is replaced by a divisor of one
    assign divisor = (i_cfg.zoom_scale == 32'd0) ? 32'd1 : i_cfg.zoom_scale;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, divisor};
    assign rem_nx = ge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];

    // truncated quotient, saturated, minus offset
    always_comb begin
        if (r_big || r_q[31]) begin
            q_sat = r_neg ? -33'sd2147483648 : 33'sd2147483647;
        end else begin
            q_sat = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
        offset = (r_state == meg_pkg::FR_FIN_I) ? i_cfg.y_offset : i_cfg.x_offset;
        diff   = q_sat - 33'(offset);
        coord  = meg_pkg::sat32(64'(diff));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            meg_pkg::FR_IDLE:  if (i_valid) n_state = meg_pkg::FR_DIV_I;
            meg_pkg::FR_DIV_I: if (r_bit == '0) n_state = meg_pkg::FR_FIN_I;
            meg_pkg::FR_FIN_I: n_state = meg_pkg::FR_DIV_R;
            meg_pkg::FR_DIV_R: if (r_bit == '0) n_state = meg_pkg::FR_FIN_R;
            meg_pkg::FR_FIN_R: n_state = meg_pkg::FR_PUSH;
            meg_pkg::FR_PUSH:  if (!i_full) n_state = meg_pkg::FR_IDLE;
            default:           n_state = meg_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == meg_pkg::FR_IDLE);
        o_push  = (r_state == meg_pkg::FR_PUSH) && !i_full;
    end

    assign o_point.cr = r_cr;
    assign o_point.ci = r_ci;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meg_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            meg_pkg::FR_IDLE: begin
                if (i_valid) begin
                    r_col <= i_col;
                    r_num <= NW'(mag_i) << meg_pkg::IMAG_SHIFT;
                    r_neg <= d_i[SW-1];
                    r_rem <= '0;
                    r_q   <= '0;
                    r_big <= 1'b0;
                    r_bit <= BW'(NW - 1);
                end
            end
            meg_pkg::FR_DIV_I, meg_pkg::FR_DIV_R: begin
                r_num <= r_num << 1;
                r_rem <= rem_nx;
                r_q   <= {r_q[30:0], ge};
                r_big <= r_big | r_q[31];
                r_bit <= r_bit - 1'b1;
            end
            meg_pkg::FR_FIN_I: begin
                r_ci  <= coord;
                r_num <= NW'(mag_r) << meg_pkg::REAL_SHIFT;
                r_neg <= d_r[SW-1];
                r_rem <= '0;
                r_q   <= '0;
                r_big <= 1'b0;
                r_bit <= BW'(NW - 1);
            end
            meg_pkg::FR_FIN_R: begin
                r_cr <= coord;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_fin_to_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == meg_pkg::FR_FIN_I) |=> (r_state == meg_pkg::FR_DIV_R))
        else $error("front: imag finish not followed by real division");
`endif

endmodule

// ===== rtl/meg_queue.sv =====
`timescale 1ns / 1ps

module meg_queue #(
    parameter int DEPTH = meg_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  meg_pkg::t_point i_data,
    output logic            o_full,
    input  logic            i_pop,
    output meg_pkg::t_point o_data,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    meg_pkg::t_point r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;
    logic            wr, rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue: fill count beyond depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue: lost a push");
`endif

endmodule

// ===== rtl/meg_back.sv =====
`timescale 1ns / 1ps

module meg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  meg_pkg::t_point i_point,
    input  logic [11:0]     i_max_iter,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_colour_code,
    output logic [6:0]      o_glyph,
    output logic [11:0]     o_escape_count
);

    meg_pkg::t_back_state r_state, n_state;

    meg_pkg::t_point    r_c;
    logic signed [31:0] r_zr, r_zi;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [11:0]        r_cnt;
    logic               r_ovalid;
    logic [11:0]        r_ocnt;

    logic signed [63:0] p_rr, p_ii, p_ri;
    logic [63:0]        mag2;
    logic               stop;
    logic signed [63:0] nr, ni;
    logic               load;

    assign p_rr = r_zr * r_zr;
    assign p_ii = r_zi * r_zi;
    assign p_ri = r_zr * r_zi;

    // both squares are non-negative, so the sum does not exceed 2^63
    assign mag2 = $unsigned(r_rr) + $unsigned(r_ii);
    assign stop = (mag2 >= meg_pkg::ESCAPE_LIMIT) || (r_cnt >= i_max_iter);
    // floor shift; doubled cross product is the product shifted by 23
    assign nr   = ((r_rr - r_ii) >>> 24) + 64'(r_c.cr);
    assign ni   = (r_ri >>> 23) + 64'(r_c.ci);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            meg_pkg::BK_IDLE: if (!i_empty) n_state = meg_pkg::BK_MUL;
            meg_pkg::BK_MUL:  n_state = meg_pkg::BK_UPD;
            meg_pkg::BK_UPD:  n_state = stop ? meg_pkg::BK_DONE : meg_pkg::BK_MUL;
            meg_pkg::BK_DONE: if (!r_ovalid || i_ready) n_state = meg_pkg::BK_IDLE;
            default:          n_state = meg_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == meg_pkg::BK_IDLE) && !i_empty;
        load  = (r_state == meg_pkg::BK_DONE) && (!r_ovalid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= meg_pkg::BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            meg_pkg::BK_IDLE: begin
                r_c   <= i_point;
                r_zr  <= '0;
                r_zi  <= '0;
                r_cnt <= '0;
            end
            meg_pkg::BK_MUL: begin
                r_rr <= p_rr;
                r_ii <= p_ii;
                r_ri <= p_ri;
            end
            meg_pkg::BK_UPD: begin
                if (!stop) begin
                    r_zr  <= meg_pkg::sat32(nr);
                    r_zi  <= meg_pkg::sat32(ni);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (load) begin
            r_ocnt <= r_cnt;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_escape_count = r_ocnt;
    assign o_colour_code  = meg_pkg::colour_of(r_ocnt[3:0]);
    assign o_glyph        = meg_pkg::glyph_of(r_ocnt[3:0]);

`ifndef SYNTH
    a_mul_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == meg_pkg::BK_MUL) |=> (r_state == meg_pkg::BK_UPD))
        else $error("back: multiply stage not followed by update");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == meg_pkg::BK_UPD && !stop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("back: iteration count did not advance");
`endif

endmodule

// ===== rtl/mandelbrot_escape_glyph.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                         payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  row, column
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  colour, glyph, count
// cfg       in         i_cfg_we                           i_cfg_index, i_cfg_data
//
// Front end maps a pixel with its shared one-bit-per-cycle divider, which runs
// the row quotient and then the column quotient.
// Back end handles a pixel in steps: a pop, a multiply and an update per iteration
// plus the final escape test, and a hand-off.
// A two-entry queue lets the front map the next pixel meanwhile.
// Synchronous active-low reset restores the register defaults; no clearing pass.
// A result waiting on i_m_axis_tready holds the back end; the front keeps mapping
// until the queue is full.

module mandelbrot_escape_glyph #(
    parameter int IMAGE_HEIGHT = meg_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // pixel_row[5:0], pixel_column[12:6], zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // colour_code[2:0], glyph[9:3],
                                          // escape_count[21:10], zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    meg_pkg::t_cfg   r_cfg;
    meg_pkg::t_point front_point, queue_point;
    logic            push, full, pop, empty;
    logic [2:0]      colour_code;
    logic [6:0]      glyph;
    logic [11:0]     escape_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zoom_scale <= meg_pkg::ZOOM_SCALE_RST;
            r_cfg.y_offset   <= '0;
            r_cfg.x_offset   <= '0;
            r_cfg.max_iter   <= meg_pkg::MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                meg_pkg::CFG_ZOOM_SCALE: r_cfg.zoom_scale <= i_cfg_data;
                meg_pkg::CFG_Y_OFFSET:   r_cfg.y_offset   <= $signed(i_cfg_data);
                meg_pkg::CFG_X_OFFSET:   r_cfg.x_offset   <= $signed(i_cfg_data);
                meg_pkg::CFG_MAX_ITER:   r_cfg.max_iter   <= i_cfg_data[11:0];
            endcase
        end
    end

    meg_front #(
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_row   (i_s_axis_tdata[5:0]),
        .i_col   (i_s_axis_tdata[12:6]),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .i_full  (full),
        .o_point (front_point)
    );

    meg_queue #(
        .DEPTH(meg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_point),
        .o_empty (empty)
    );

    meg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_point        (queue_point),
        .i_max_iter     (r_cfg.max_iter),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_colour_code  (colour_code),
        .o_glyph        (glyph),
        .o_escape_count (escape_count)
    );

    assign o_m_axis_tdata = {2'b00, escape_count, glyph, colour_code};

endmodule
